FILE: rtl/pat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pat_pkg: shared types and constants of the point affine transform
// Register indexes, fixed-point fraction widths, copy kinds and scale modes.
// ----------------------------------------------------------------------------
package pat_pkg;

  typedef enum logic [2:0] {
    REG_COS    = 3'd0,
    REG_SIN    = 3'd1,
    REG_SCALE  = 3'd2,
    REG_SHX    = 3'd3,
    REG_SHY    = 3'd4,
    REG_SFTX   = 3'd5,
    REG_SFTY   = 3'd6,
    REG_MIRROR = 3'd7
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_XFORM = 2'd0,
    KIND_MX    = 2'd1,
    KIND_MY    = 2'd2,
    KIND_MXY   = 2'd3
  } copy_kind_t;

  typedef enum logic [1:0] {
    SCL_NONE  = 2'd0,
    SCL_LIM_X = 2'd1,
    SCL_LIM_Y = 2'd2
  } scale_mode_t;

  localparam int ROT_FRAC   = 14;
  localparam int SHEAR_FRAC = 12;
  localparam int SCALE_FRAC = 8;
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;
  localparam int OUT_W      = 8;

endpackage

FILE: rtl/point_affine_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// point_affine_transform: rotate, scale, shear and translate image points
// Fully pipelined point transform with clamping and mirrored copies.
// ----------------------------------------------------------------------------
// Each input item is one point; it runs through a pipeline of PW+8 stages
// (16 at the default 256-pixel image), where PW is the coordinate width and
// PW stages form the restoring divider of the scale step. A new item can
// enter every cycle unless stalled. The last stage emits one to four result
// items, one per cycle while out_ready is high, and takes no new item until
// the last is taken. Configuration is written through an APB port that is
// always ready and must only be written while the pipeline is empty.
// ----------------------------------------------------------------------------
module point_affine_transform #(
  parameter int IMAGE_SIZE       = 256,
  parameter int TRANSFORM_CENTER = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pat_pkg::ADDR_W-1:0]  paddr,
  input  logic [pat_pkg::DATA_W-1:0]  pwdata,
  output logic [pat_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [7:0]                  in_point_x,
  input  logic [7:0]                  in_point_y,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pat_pkg::OUT_W-1:0]   out_x,
  output logic [pat_pkg::OUT_W-1:0]   out_y,
  output logic [1:0]                  out_copy_kind,
  output logic                        out_last_copy
);
  import pat_pkg::*;

  localparam int PW_S  = $clog2(IMAGE_SIZE);
  localparam int PW_C  = $clog2(TRANSFORM_CENTER + 1);
  localparam int PW_SC = (PW_S > PW_C) ? PW_S : PW_C;
  localparam int PW    = (PW_SC < 8) ? 8 : PW_SC;
  localparam int DW    = PW + 1;
  localparam int MW    = DW + 16;
  localparam int SW    = PW + 20;
  localparam int QW    = PW;
  localparam int NW    = 2 * PW + 2;
  localparam int QSW   = PW + SCALE_FRAC;
  localparam int M_A   = (TRANSFORM_CENTER < IMAGE_SIZE - TRANSFORM_CENTER) ?
                         TRANSFORM_CENTER : IMAGE_SIZE - TRANSFORM_CENTER;
  localparam int M_INT = (M_A < 0) ? 0 : M_A;
  localparam int H2    = 2 * (IMAGE_SIZE / 2);
  localparam int FS    = 4 + QW;
  localparam int NS    = FS + 4;
  localparam logic signed [SW-1:0] CEN_S = SW'(TRANSFORM_CENTER);
  localparam logic [PW+15:0] MK = (PW + 16)'(M_INT * (2 ** SCALE_FRAC));

  typedef struct packed {
    scale_mode_t     mode;
    logic            sx;
    logic            sy;
    logic [QSW-1:0]  qx0;
    logic [QSW-1:0]  qy0;
    logic [NW-1:0]   rem;
    logic [PW:0]     d2;
    logic [QW-1:0]   q;
  } dv_t;

  function automatic logic signed [SW-1:0] rnd_sh(input logic signed [SW-1:0] v,
                                                  input int f);
    logic [SW-1:0] mag;
    logic [SW-1:0] qq;
    mag = v[SW-1] ? SW'(-v) : SW'(v);
    qq  = (mag + (SW'(1) << (f - 1))) >> f;
    return v[SW-1] ? -$signed(qq) : $signed(qq);
  endfunction

  function automatic logic [PW-1:0] clampc(input logic signed [SW-1:0] v);
    if (v < 0) begin
      return '0;
    end else if (v > SW'(IMAGE_SIZE - 1)) begin
      return PW'(IMAGE_SIZE - 1);
    end
    return v[PW-1:0];
  endfunction

  // Configuration registers
  logic signed [15:0] cos_coef_r, sin_coef_r, shear_x_r, shear_y_r;
  logic        [15:0] scale_factor_r;
  logic signed [8:0]  shift_x_r, shift_y_r;
  logic        [2:0]  mirror_mask_r;
  reg_idx_t           cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cos_coef_r     <= 16'sd16384;
      sin_coef_r     <= '0;
      scale_factor_r <= 16'd256;
      shear_x_r      <= '0;
      shear_y_r      <= '0;
      shift_x_r      <= '0;
      shift_y_r      <= '0;
      mirror_mask_r  <= '0;
    end else if (psel && penable && pwrite && pready) begin
      case (cfg_idx)
        REG_COS:    cos_coef_r     <= pwdata[15:0];
        REG_SIN:    sin_coef_r     <= pwdata[15:0];
        REG_SCALE:  scale_factor_r <= pwdata[15:0];
        REG_SHX:    shear_x_r      <= pwdata[15:0];
        REG_SHY:    shear_y_r      <= pwdata[15:0];
        REG_SFTX:   shift_x_r      <= pwdata[8:0];
        REG_SFTY:   shift_y_r      <= pwdata[8:0];
        REG_MIRROR: mirror_mask_r  <= pwdata[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_COS:    prdata = {16'b0, cos_coef_r};
      REG_SIN:    prdata = {16'b0, sin_coef_r};
      REG_SCALE:  prdata = {16'b0, scale_factor_r};
      REG_SHX:    prdata = {16'b0, shear_x_r};
      REG_SHY:    prdata = {16'b0, shear_y_r};
      REG_SFTX:   prdata = {23'b0, shift_x_r};
      REG_SFTY:   prdata = {23'b0, shift_y_r};
      REG_MIRROR: prdata = {29'b0, mirror_mask_r};
      default:    prdata = '0;
    endcase
  end

  // Pipeline valid bits and per-stage ready chain
  logic [NS-1:0] v_r, v_nxt;
  logic [NS:0]   rdy;

  always_comb begin
    rdy[NS] = out_ready && out_last_copy;
    for (int k = NS - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    for (int k = 0; k < NS; k++) begin
      if (rdy[k]) begin
        v_nxt[k] = (k == 0) ? in_valid : v_r[(k == 0) ? 0 : k - 1];
      end else begin
        v_nxt[k] = v_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready = rdy[0];

  // Stage 0: rotation products
  logic signed [DW-1:0] dx0, dy0;
  logic signed [MW-1:0] pxc_r, pys_r, pxs_r, pyc_r;
  logic signed [MW-1:0] pxc_nxt, pys_nxt, pxs_nxt, pyc_nxt;

  always_comb begin
    dx0     = DW'(in_point_x) - DW'(TRANSFORM_CENTER);
    dy0     = DW'(in_point_y) - DW'(TRANSFORM_CENTER);
    pxc_nxt = dx0 * cos_coef_r;
    pys_nxt = dy0 * sin_coef_r;
    pxs_nxt = dx0 * sin_coef_r;
    pyc_nxt = dy0 * cos_coef_r;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      pxc_r <= pxc_nxt;
      pys_r <= pys_nxt;
      pxs_r <= pxs_nxt;
      pyc_r <= pyc_nxt;
    end
  end

  // Stage 1: rotation rounding and clamp
  logic signed [SW-1:0] rsx, rsy;
  logic [PW-1:0]        x1_r, y1_r, x1_nxt, y1_nxt;

  always_comb begin
    rsx    = SW'(pxc_r) - SW'(pys_r);
    rsy    = SW'(pxs_r) + SW'(pyc_r);
    x1_nxt = clampc(rnd_sh(rsx, ROT_FRAC) + CEN_S);
    y1_nxt = clampc(rnd_sh(rsy, ROT_FRAC) + CEN_S);
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      x1_r <= x1_nxt;
      y1_r <= y1_nxt;
    end
  end

  // Stage 2: scale offsets and requested-scale products
  logic signed [DW-1:0] dx2, dy2;
  logic [PW-1:0]        ax_r, ay_r, ax_nxt, ay_nxt;
  logic                 sx_r, sy_r;
  logic [PW+15:0]       pa_r, pb_r, pa_nxt, pb_nxt;

  always_comb begin
    dx2    = DW'(x1_r) - DW'(TRANSFORM_CENTER);
    dy2    = DW'(y1_r) - DW'(TRANSFORM_CENTER);
    ax_nxt = dx2[DW-1] ? PW'(-dx2) : PW'(dx2);
    ay_nxt = dy2[DW-1] ? PW'(-dy2) : PW'(dy2);
    pa_nxt = scale_factor_r * ax_nxt;
    pb_nxt = scale_factor_r * ay_nxt;
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      ax_r <= ax_nxt;
      ay_r <= ay_nxt;
      sx_r <= dx2[DW-1];
      sy_r <= dy2[DW-1];
      pa_r <= pa_nxt;
      pb_r <= pb_nxt;
    end
  end

  // Stage 3: safe-limit selection and divider operands
  dv_t           dv_r [0:QW];
  dv_t           dv0_nxt;
  logic          c1, c2;
  logic [PW-1:0] dsel, osel;

  always_comb begin
    c1   = (ax_r != '0) && (MK < pa_r);
    c2   = (ay_r != '0) && (c1 ? ((M_INT != 0) && (ax_r < ay_r)) : (MK < pb_r));
    dsel = c2 ? ay_r : ax_r;
    osel = c2 ? ax_r : ay_r;
    dv0_nxt.mode = c2 ? SCL_LIM_Y : (c1 ? SCL_LIM_X : SCL_NONE);
    dv0_nxt.sx   = sx_r;
    dv0_nxt.sy   = sy_r;
    dv0_nxt.qx0  = QSW'((pa_r + (PW + 16)'(128)) >> SCALE_FRAC);
    dv0_nxt.qy0  = QSW'((pb_r + (PW + 16)'(128)) >> SCALE_FRAC);
    dv0_nxt.rem  = ((NW'(osel) * NW'(M_INT)) << 1) + NW'(dsel);
    dv0_nxt.d2   = {dsel, 1'b0};
    dv0_nxt.q    = '0;
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      dv_r[0] <= dv0_nxt;
    end
  end

  // Stages 4 .. 3+QW: restoring divider, one quotient bit per stage
  for (genvar j = 0; j < QW; j++) begin : g_div
    dv_t           st_nxt;
    logic [NW-1:0] sub;

    always_comb begin
      st_nxt = dv_r[j];
      sub    = NW'(dv_r[j].d2) << (QW - 1 - j);
      if (dv_r[j].rem >= sub) begin
        st_nxt.rem          = dv_r[j].rem - sub;
        st_nxt.q[QW-1-j]    = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[4+j]) begin
        dv_r[j+1] <= st_nxt;
      end
    end
  end

  // Stage FS: apply scale
  logic [QSW-1:0]       mx, my;
  logic signed [SW-1:0] sxv, syv;
  logic [PW-1:0]        x2_r, y2_r, x2_nxt, y2_nxt;

  always_comb begin
    mx = dv_r[QW].qx0;
    my = dv_r[QW].qy0;
    if (dv_r[QW].mode == SCL_LIM_X) begin
      mx = QSW'(M_INT);
      my = QSW'(dv_r[QW].q);
    end else if (dv_r[QW].mode == SCL_LIM_Y) begin
      mx = QSW'(dv_r[QW].q);
      my = QSW'(M_INT);
    end
    sxv    = dv_r[QW].sx ? CEN_S - SW'(mx) : CEN_S + SW'(mx);
    syv    = dv_r[QW].sy ? CEN_S - SW'(my) : CEN_S + SW'(my);
    x2_nxt = clampc(sxv);
    y2_nxt = clampc(syv);
  end

  always_ff @(posedge clk) begin
    if (rdy[FS]) begin
      x2_r <= x2_nxt;
      y2_r <= y2_nxt;
    end
  end

  // Stage FS+1: shear products
  logic signed [PW+16:0] phx_r, phy_r, phx_nxt, phy_nxt;
  logic [PW-1:0]         x2d_r, y2d_r;

  always_comb begin
    phx_nxt = shear_x_r * $signed({1'b0, y2_r});
    phy_nxt = shear_y_r * $signed({1'b0, x2_r});
  end

  always_ff @(posedge clk) begin
    if (rdy[FS+1]) begin
      phx_r <= phx_nxt;
      phy_r <= phy_nxt;
      x2d_r <= x2_r;
      y2d_r <= y2_r;
    end
  end

  // Stage FS+2: shear rounding and clamp
  logic signed [SW-1:0] shs_x, shs_y;
  logic [PW-1:0]        x3_r, y3_r, x3_nxt, y3_nxt;

  always_comb begin
    shs_x  = (SW'(x2d_r) << SHEAR_FRAC) + SW'(phx_r);
    shs_y  = (SW'(y2d_r) << SHEAR_FRAC) + SW'(phy_r);
    x3_nxt = clampc(rnd_sh(shs_x, SHEAR_FRAC));
    y3_nxt = clampc(rnd_sh(shs_y, SHEAR_FRAC));
  end

  always_ff @(posedge clk) begin
    if (rdy[FS+2]) begin
      x3_r <= x3_nxt;
      y3_r <= y3_nxt;
    end
  end

  // Stage FS+3: translation, mirrors and result emission
  logic [PW-1:0] x4_r, y4_r, xm_r, ym_r, x4_nxt, y4_nxt, xm_nxt, ym_nxt;
  logic [3:0]    pend_r, pend_nxt;
  copy_kind_t    kind;

  always_comb begin
    x4_nxt = clampc(SW'(x3_r) + SW'(shift_x_r));
    y4_nxt = clampc(SW'(y3_r) + SW'(shift_y_r));
    xm_nxt = clampc(SW'(H2) - SW'(x4_nxt));
    ym_nxt = clampc(SW'(H2) - SW'(y4_nxt));
    if (rdy[NS-1]) begin
      pend_nxt = {mirror_mask_r, 1'b1};
    end else if (out_valid && out_ready) begin
      pend_nxt = pend_r & (pend_r - 4'd1);
    end else begin
      pend_nxt = pend_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[NS-1]) begin
      x4_r <= x4_nxt;
      y4_r <= y4_nxt;
      xm_r <= xm_nxt;
      ym_r <= ym_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  always_comb begin
    if (pend_r[0]) begin
      kind = KIND_XFORM;
    end else if (pend_r[1]) begin
      kind = KIND_MX;
    end else if (pend_r[2]) begin
      kind = KIND_MY;
    end else begin
      kind = KIND_MXY;
    end
  end

  assign out_valid     = v_r[NS-1];
  assign out_copy_kind = kind;
  assign out_last_copy = $onehot(pend_r);
  assign out_x         = kind[0] ? xm_r[OUT_W-1:0] : x4_r[OUT_W-1:0];
  assign out_y         = kind[1] ? ym_r[OUT_W-1:0] : y4_r[OUT_W-1:0];

  a_more_copies: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last_copy |=> out_valid)
    else $error("Result items of a point were dropped.");

  a_pending: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("Output valid without a pending copy.");

  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("Accepted item did not enter the pipeline.");

  a_quot: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[FS-1] && dv_r[QW].mode != SCL_NONE |-> dv_r[QW].q <= QW'(M_INT))
    else $error("Scale quotient exceeds the safe limit.");

endmodule
